FILE: hw/rtl/bcp_pkg.sv
// Shared types for the braille character-set text parser.
// Parser states, event kinds and the register and result bundles.
// No dependencies.
package bcp_pkg;

   localparam int LINE_BITS_DEFAULT = 16;
   localparam int ERR_LINE_BITS     = 16;

   typedef enum logic [3:0] {
      ST_HDR     = 4'd0,
      ST_WS1     = 4'd1,
      ST_NAM     = 4'd2,
      ST_NEWLINE = 4'd3,
      ST_ERREOL  = 4'd4,
      ST_HX1     = 4'd5,
      ST_HX2     = 4'd6,
      ST_HX3     = 4'd7,
      ST_CDL     = 4'd8,
      ST_UNI1    = 4'd9,
      ST_UNI2    = 4'd10,
      ST_WS2     = 4'd11,
      ST_LETR    = 4'd12,
      ST_FTR     = 4'd13
   } parse_state_type;

   typedef enum logic [2:0] {
      EV_NONE     = 3'd0,
      EV_NAME     = 3'd1,
      EV_NAMEDONE = 3'd2,
      EV_LETTER   = 3'd3,
      EV_MAPPING  = 3'd4
   } event_kind_type;

   typedef struct packed {
      parse_state_type state;
      logic [7:0]      match_or_dots;
      logic [7:0]      digit_dots;
      logic            done;
   } parse_regs_type;

   typedef struct packed {
      event_kind_type           kind;
      logic [7:0]               data_byte;
      logic [7:0]               dot_mask;
      logic                     syntax_error;
      logic [ERR_LINE_BITS-1:0] error_line;
   } result_type;

endpackage

FILE: hw/rtl/bcp_step.sv
// One-byte transition of the parser: next register values and the result item.
// Purely combinational; depends on bcp_pkg.
module bcp_step #(
   parameter int LINE_BITS = bcp_pkg::LINE_BITS_DEFAULT
) (
   input  bcp_pkg::parse_regs_type regs,
   input  logic [LINE_BITS-1:0]    line_count,
   input  logic [7:0]              in_byte,
   output bcp_pkg::parse_regs_type regs_in,
   output logic [LINE_BITS-1:0]    line_count_in,
   output bcp_pkg::result_type     result
);
   import bcp_pkg::*;

   localparam logic [7:0] UTF8_LEAD   = 8'he2;
   localparam logic [7:0] UNI_LO      = 8'ha0;
   localparam logic [7:0] UNI_HI      = 8'ha3;
   localparam logic [7:0] CONT_MASK   = 8'hc0;
   localparam logic [7:0] CONT_TAG    = 8'h80;
   localparam logic [7:0] CONT_BITS   = 8'h3f;
   localparam logic [7:0] CHAR_CR     = 8'h0d;
   localparam logic [7:0] CHAR_LF     = 8'h0a;
   localparam logic [7:0] CHAR_TAB    = 8'h09;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_EOF    = 8'h00;

   logic [7:0]           c;
   logic [7:0]           mod;
   logic [LINE_BITS-1:0] line_inc;
   logic                 is_eol;
   logic                 is_blank;
   logic                 is_digit18;
   logic [7:0]           digit_bit;
   logic                 hex_ok;
   logic [3:0]           hex_val;
   logic                 eof_ends;
   logic                 is_cont;
   logic                 is_uni1;
   logic                 err;
   logic                 err_inc;
   logic [31:0]          line_wide;

   assign c          = in_byte;
   assign mod        = regs.match_or_dots;
   assign line_inc   = line_count + LINE_BITS'(1);
   assign is_eol     = (c == CHAR_CR) || (c == CHAR_LF);
   assign is_blank   = (c == CHAR_SPACE) || (c == CHAR_TAB);
   assign is_digit18 = (c >= "1") && (c <= "8");
   assign digit_bit  = 8'b1 << c[2:0] - 3'd1;
   assign is_cont    = (c & CONT_MASK) == CONT_TAG;
   assign is_uni1    = (c >= UNI_LO) && (c <= UNI_HI);
   assign eof_ends   = (c == CHAR_EOF) && (regs.state != ST_UNI1)
                       && (regs.state != ST_UNI2);

   always_comb begin
      hex_ok  = 1'b0;
      hex_val = c[3:0];
      if (c >= "0" && c <= "9") begin
         hex_ok = 1'b1;
      end else if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) begin
         hex_ok  = 1'b1;
         hex_val = c[3:0] + 4'd9;
      end
   end

   // next register values
   always_comb begin
      regs_in       = regs;
      line_count_in = line_count;
      if (!regs.done) begin
         if (eof_ends) begin
            regs_in.done = 1'b1;
         end else begin
            case (regs.state)
               ST_WS1, ST_WS2: begin
                  if (is_eol) begin
                     line_count_in         = line_inc;
                     regs_in.match_or_dots = c;
                     regs_in.state = (regs.state == ST_WS1) ? ST_HDR : ST_NEWLINE;
                  end else if (!is_blank) begin
                     regs_in.state = (regs.state == ST_WS1) ? ST_NAM : ST_LETR;
                  end
               end
               ST_NAM, ST_LETR, ST_ERREOL: begin
                  if (is_eol) begin
                     line_count_in         = line_inc;
                     regs_in.match_or_dots = c;
                     regs_in.state         = ST_NEWLINE;
                  end
               end
               ST_NEWLINE: begin
                  if (c == "0") begin
                     regs_in.state = ST_HX1;
                  end else if (is_digit18) begin
                     regs_in.digit_dots = digit_bit;
                     regs_in.state      = ST_CDL;
                  end else if (c == UTF8_LEAD) begin
                     regs_in.state = ST_UNI1;
                  end else if (c == "!") begin
                     regs_in.match_or_dots = c;
                     regs_in.state         = ST_FTR;
                  end else if (is_eol) begin
                     // CR after LF (or LF after CR) belongs to the same line end
                     if (mod != ((c == CHAR_CR) ? CHAR_LF : CHAR_CR)) begin
                        line_count_in         = line_inc;
                        regs_in.match_or_dots = c;
                     end
                  end else begin
                     regs_in.state = ST_ERREOL;
                  end
               end
               ST_HX1, ST_HX2, ST_HX3, ST_CDL, ST_UNI1, ST_UNI2, ST_FTR: begin
                  if (is_eol) begin
                     line_count_in         = line_inc;
                     regs_in.match_or_dots = c;
                     regs_in.state         = ST_NEWLINE;
                  end else begin
                     case (regs.state)
                        ST_HX1: begin
                           regs_in.state = (c == "x" || c == "X") ? ST_HX2 : ST_ERREOL;
                        end
                        ST_HX2: begin
                           if (hex_ok) begin
                              regs_in.match_or_dots = {hex_val, 4'h0};
                              regs_in.state         = ST_HX3;
                           end else begin
                              regs_in.state = ST_ERREOL;
                           end
                        end
                        ST_HX3: begin
                           if (hex_ok) begin
                              regs_in.match_or_dots = mod | {4'h0, hex_val};
                              regs_in.state         = ST_WS2;
                           end else begin
                              regs_in.state = ST_ERREOL;
                           end
                        end
                        ST_CDL: begin
                           if (is_digit18) begin
                              regs_in.digit_dots = regs.digit_dots | digit_bit;
                           end else if (is_blank) begin
                              regs_in.match_or_dots = regs.digit_dots;
                              regs_in.digit_dots    = 8'h00;
                              regs_in.state         = ST_WS2;
                           end else if (c != ",") begin
                              regs_in.state = ST_ERREOL;
                           end
                        end
                        ST_UNI1: begin
                           if (is_uni1) begin
                              regs_in.match_or_dots = {c[1:0], 6'h00};
                              regs_in.state         = ST_UNI2;
                           end else begin
                              regs_in.state = ST_ERREOL;
                           end
                        end
                        ST_UNI2: begin
                           if (is_cont) begin
                              regs_in.match_or_dots = mod | (c & CONT_BITS);
                              regs_in.state         = ST_WS2;
                           end else begin
                              regs_in.state = ST_ERREOL;
                           end
                        end
                        default: begin
                           // footer: each char must follow its predecessor
                           case (c)
                              "U": regs_in.match_or_dots = (mod == "!") ? c : 8'h00;
                              "T": regs_in.match_or_dots = (mod == "U") ? c : 8'h00;
                              "F": regs_in.match_or_dots = (mod == "T") ? c : 8'h00;
                              "-": regs_in.match_or_dots = (mod == "F") ? c : 8'h00;
                              "8": regs_in.match_or_dots = (mod == "-") ? c : 8'h00;
                              " ": regs_in.match_or_dots = (mod == "8") ? c : 8'h00;
                              "E": regs_in.match_or_dots = (mod == " ") ? c : 8'h00;
                              "N": regs_in.match_or_dots = (mod == "E") ? c : 8'h00;
                              "D": regs_in.done = (mod == "N");
                              default: regs_in.state = ST_ERREOL;
                           endcase
                        end
                     endcase
                  end
               end
               default: begin
                  // header search, also for the unused codes
                  regs_in.state = ST_HDR;
                  case (c)
                     "!": regs_in.match_or_dots = c;
                     "U": regs_in.match_or_dots = (mod == "!") ? c : 8'h00;
                     "T": regs_in.match_or_dots = (mod == "U") ? c : 8'h00;
                     "F": regs_in.match_or_dots = (mod == "T") ? c : 8'h00;
                     "-": regs_in.match_or_dots = (mod == "F") ? c : 8'h00;
                     "8": regs_in.match_or_dots = (mod == "-") ? c : 8'h00;
                     " ": regs_in.match_or_dots = (mod == "8") ? c : 8'h00;
                     "B": regs_in.match_or_dots = (mod == " ") ? c : 8'h00;
                     "E": regs_in.match_or_dots = (mod == "B") ? c : 8'h00;
                     "G": regs_in.match_or_dots = (mod == "E") ? c : 8'h00;
                     "I": regs_in.match_or_dots = (mod == "G") ? c : 8'h00;
                     "N": begin
                        if (mod == "I") regs_in.state = ST_WS1;
                        else regs_in.match_or_dots = 8'h00;
                     end
                     CHAR_CR, CHAR_LF: begin
                        if (mod != ((c == CHAR_CR) ? CHAR_LF : CHAR_CR)) begin
                           line_count_in         = line_inc;
                           regs_in.match_or_dots = c;
                        end
                     end
                     default: regs_in.match_or_dots = 8'h00;
                  endcase
               end
            endcase
         end
      end
   end

   // result item
   always_comb begin
      result.kind      = EV_NONE;
      result.data_byte = 8'h00;
      result.dot_mask  = 8'h00;
      err              = 1'b0;
      err_inc          = 1'b0;
      if (!regs.done) begin
         if (eof_ends) begin
            err = 1'b1;
         end else begin
            case (regs.state)
               ST_WS1, ST_WS2: begin
                  if (is_eol) begin
                     err     = 1'b1;
                     err_inc = 1'b1;
                  end else if (!is_blank) begin
                     result.kind      = (regs.state == ST_WS1) ? EV_NAME : EV_LETTER;
                     result.data_byte = c;
                  end
               end
               ST_NAM, ST_LETR: begin
                  if (is_eol) begin
                     if (regs.state == ST_NAM) begin
                        result.kind = EV_NAMEDONE;
                     end else begin
                        result.kind     = EV_MAPPING;
                        result.dot_mask = mod;
                     end
                  end else begin
                     result.kind      = (regs.state == ST_NAM) ? EV_NAME : EV_LETTER;
                     result.data_byte = c;
                  end
               end
               ST_NEWLINE: begin
                  err = !(c == "0" || is_digit18 || c == UTF8_LEAD || c == "!" || is_eol);
               end
               ST_HX1: begin
                  err     = !(c == "x" || c == "X");
                  err_inc = is_eol;
               end
               ST_HX2, ST_HX3: begin
                  err     = !hex_ok;
                  err_inc = is_eol;
               end
               ST_CDL: begin
                  err     = !(c == "," || is_digit18 || is_blank);
                  err_inc = is_eol;
               end
               ST_UNI1: begin
                  err     = !is_uni1;
                  err_inc = is_eol;
               end
               ST_UNI2: begin
                  err     = is_eol || !is_cont;
                  err_inc = is_eol;
               end
               ST_FTR: begin
                  err     = !(c == "U" || c == "T" || c == "F" || c == "-" || c == "8"
                              || c == " " || c == "E" || c == "N" || c == "D");
                  err_inc = is_eol;
               end
               default: begin
               end
            endcase
         end
      end
      line_wide           = err_inc ? 32'(line_inc) : 32'(line_count);
      result.syntax_error = err;
      result.error_line   = err ? line_wide[ERR_LINE_BITS-1:0] : '0;
   end

endmodule

FILE: hw/rtl/braille_charset_text_parser.sv
// Top level of the braille character-set text parser: state and result registers.
// Uses bcp_step for the byte transition; depends on bcp_pkg.
// The result item of an accepted byte is registered and shown on rsp_ in the next cycle.
// Throughput: one byte per cycle; the result register lets a new byte in
// whenever the held result is taken in the same cycle or none is held.
// Reset: synchronous; header search, line counter 1, no result held.
module braille_charset_text_parser #(
   parameter int LINE_BITS = bcp_pkg::LINE_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [7:0] data_byte, [15:8] dot_mask, [31:16] error_line
   output logic [7:0]  rsp_tuser    // [2:0] event_kind, [3] syntax_error, [4] finished
);
   import bcp_pkg::*;

   parse_regs_type       regs_ff, regs_in;
   logic [LINE_BITS-1:0] line_ff, line_in;
   result_type           step_res;
   result_type           res_ff;
   logic                 fin_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 accept;

   bcp_step #(.LINE_BITS(LINE_BITS)) u_step (
      .regs          (regs_ff),
      .line_count    (line_ff),
      .in_byte       (req_tdata),
      .regs_in       (regs_in),
      .line_count_in (line_in),
      .result        (step_res)
   );

   assign req_tready   = !rsp_valid_ff || rsp_tready;
   assign accept       = req_tvalid && req_tready;
   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff.state         <= ST_HDR;
         regs_ff.match_or_dots <= 8'h00;
         regs_ff.digit_dots    <= 8'h00;
         regs_ff.done          <= 1'b0;
         line_ff               <= LINE_BITS'(1);
         rsp_valid_ff          <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            regs_ff <= regs_in;
            line_ff <= line_in;
         end
      end
   end

   // result payload: hold while the sink stalls
   always_ff @(posedge clock) begin
      if (accept) begin
         res_ff <= step_res;
         fin_ff <= regs_in.done;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {res_ff.error_line, res_ff.dot_mask, res_ff.data_byte};
   assign rsp_tuser  = {3'b000, fin_ff, res_ff.syntax_error, res_ff.kind};

   a_done_sticky: assert property (@(posedge clock) disable iff (reset)
      regs_ff.done |=> regs_ff.done)
      else $error("finished flag dropped");

   a_done_quiet: assert property (@(posedge clock) disable iff (reset)
      (accept && regs_ff.done) |=> (res_ff.kind == EV_NONE && !res_ff.syntax_error
                                    && fin_ff))
      else $error("event after parsing finished");

   a_line_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !res_ff.syntax_error) |-> (res_ff.error_line == '0))
      else $error("error line set without an error");

   a_accept_valid: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted item gave no result");

endmodule
